### sv/irc_pkg.sv
// Shared types, constants and character helpers for the radix converter.
`timescale 1ns / 1ps

package irc_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_DIGITS = 32;
	localparam int DIGIT_W    = 4;
	localparam int BASE_W     = 5;
	localparam int NIBBLES    = VALUE_BITS / DIGIT_W;
	localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
	localparam int NIB_CNT_W  = $clog2(NIBBLES);
	localparam int MUL_CNT_W  = $clog2(BASE_W);
	localparam int STACK_W    = MAX_DIGITS * DIGIT_W;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 1'd1;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_F     = 8'h46;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

	typedef struct packed {
		logic [7:0] digit_char;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		if (b < BASE_MIN) begin
			return BASE_MIN;
		end else if (b > BASE_MAX) begin
			return BASE_MAX;
		end
		return b;
	endfunction

	// Return {is_digit, value}.
	function automatic logic [DIGIT_W:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = c - CHAR_ZERO;
			return {1'b1, d[DIGIT_W-1:0]};
		end else if (c >= CHAR_A && c <= CHAR_F) begin
			d = c - CHAR_A + 8'd10;
			return {1'b1, d[DIGIT_W-1:0]};
		end
		return '0;
	endfunction

	function automatic logic [7:0] char_of(input logic [DIGIT_W-1:0] d);
		if (d < 4'd10) begin
			return CHAR_ZERO + {4'd0, d};
		end
		return CHAR_A + {4'd0, d} - 8'd10;
	endfunction

endpackage

### sv/irc_digit_div.sv
// One radix-16 step of long division by a small base: four restoring bit steps.
`timescale 1ns / 1ps

module irc_digit_div (
	input  logic [irc_pkg::DIGIT_W-1:0] rem,
	input  logic [irc_pkg::DIGIT_W-1:0] nib,
	input  logic [irc_pkg::BASE_W-1:0]  base,
	output logic [irc_pkg::DIGIT_W-1:0] quot,
	output logic [irc_pkg::DIGIT_W-1:0] rem_next
);

	logic [irc_pkg::BASE_W-1:0] r;

	always_comb begin
		r    = {1'b0, rem};
		quot = '0;
		for (int i = irc_pkg::DIGIT_W - 1; i >= 0; i--) begin
			// r stays below base, so its top bit is free for the shift
			r = {r[irc_pkg::BASE_W-2:0], nib[i]};
			if (r >= base) begin
				r       = r - base;
				quot[i] = 1'b1;
			end
		end
		rem_next = r[irc_pkg::DIGIT_W-1:0];
	end

endmodule

### sv/integer_radix_converter_core.sv
// Top level: character parser, serial multiply-add, serial division and digit emitter.
// Flow: a non-digit character is accepted directly; a digit is accepted and then takes
// one shift-add per bit of the 5-bit source base. A last character then goes through
// sign handling and the nibble-serial divider for each output digit (up to
// 32 digits), then one cycle per emitted character while the output is not stalled.
// Reset clears the number state and sets the bases to 10 (source) and 2 (target).
`timescale 1ns / 1ps

module integer_radix_converter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  irc_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output irc_pkg::out_t                    out_data,
	input  logic                             cfg_we,
	input  logic [irc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irc_pkg::BASE_W-1:0]       cfg_data
);

	localparam int VB = irc_pkg::VALUE_BITS;
	localparam int DW = irc_pkg::DIGIT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SIGN  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OSIGN = 3'd4;
	localparam logic [2:0] ST_ODIG  = 3'd5;

	logic [2:0]                         state_q;
	logic [irc_pkg::BASE_W-1:0]         src_base_q;
	logic [irc_pkg::BASE_W-1:0]         tgt_base_q;
	logic [VB-1:0]                      acc_q;
	logic                               neg_flag_q;
	logic                               first_q;
	logic                               last_q;
	logic                               sign_q;
	logic [irc_pkg::COUNT_W-1:0]        count_q;
	logic [irc_pkg::NIB_CNT_W-1:0]      nib_cnt_q;
	logic [irc_pkg::MUL_CNT_W-1:0]      mul_cnt_q;
	logic                               out_valid_q;
	logic [VB-1:0]                      prod_q;
	logic [DW-1:0]                      digit_q;
	logic [VB-1:0]                      div_q;
	logic [DW-1:0]                      rem_q;
	logic [irc_pkg::STACK_W-1:0]        stack_q;
	irc_pkg::out_t                      out_data_q;

	logic                               in_acc;
	logic [DW:0]                        dv;
	logic                               is_minus;
	logic [VB-1:0]                      prod_next;
	logic [VB-1:0]                      acc_neg;
	logic                               sign_val;
	logic [VB-1:0]                      mag;
	logic [DW-1:0]                      quot;
	logic [DW-1:0]                      rem_next;
	logic [VB-1:0]                      div_next;
	logic                               nib_done;
	logic                               more_digits;
	logic                               load_ok;
	logic                               load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign dv        = irc_pkg::digit_value(in_data.digit_char);
	assign is_minus  = !first_q && (in_data.digit_char == irc_pkg::CHAR_MINUS);

	// Horner step, one base bit per cycle, MSB first; add the digit on the final bit.
	assign prod_next = {prod_q[VB-2:0], 1'b0}
		+ (src_base_q[mul_cnt_q] ? acc_q : '0)
		+ ((mul_cnt_q == '0) ? VB'(digit_q) : '0);

	assign acc_neg  = '0 - acc_q;
	assign sign_val = neg_flag_q ? acc_neg[VB-1] : acc_q[VB-1];
	assign mag      = (sign_val == neg_flag_q) ? acc_q : acc_neg;

	irc_digit_div u_div (
		.rem      (rem_q),
		.nib      (div_q[VB-1 -: DW]),
		.base     (tgt_base_q),
		.quot     (quot),
		.rem_next (rem_next)
	);

	assign div_next    = {div_q[VB-DW-1:0], quot};
	assign nib_done    = (nib_cnt_q == irc_pkg::NIB_CNT_W'(irc_pkg::NIBBLES - 1));
	assign more_digits = (div_next != '0)
		&& (count_q < irc_pkg::COUNT_W'(irc_pkg::MAX_DIGITS - 1));

	assign load_ok = !out_valid_q || !out_stall;
	assign load    = load_ok && (state_q == ST_OSIGN || state_q == ST_ODIG);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			src_base_q  <= 5'd10;
			tgt_base_q  <= 5'd2;
			acc_q       <= '0;
			neg_flag_q  <= 1'b0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			sign_q      <= 1'b0;
			count_q     <= '0;
			nib_cnt_q   <= '0;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					irc_pkg::REG_SOURCE_BASE: src_base_q <= irc_pkg::clamp_base(cfg_data);
					irc_pkg::REG_TARGET_BASE: tgt_base_q <= irc_pkg::clamp_base(cfg_data);
					default: ;
				endcase
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						first_q <= 1'b1;
						last_q  <= in_data.last_char;
						priority if (is_minus) begin
							neg_flag_q <= 1'b1;
							state_q    <= in_data.last_char ? ST_SIGN : ST_IDLE;
						end else if (dv[DW]) begin
							mul_cnt_q <= irc_pkg::MUL_CNT_W'(irc_pkg::BASE_W - 1);
							state_q   <= ST_MUL;
						end else begin
							state_q <= in_data.last_char ? ST_SIGN : ST_IDLE;
						end
					end
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q - 1'b1;
					if (mul_cnt_q == '0) begin
						acc_q   <= prod_next;
						state_q <= last_q ? ST_SIGN : ST_IDLE;
					end
				end
				ST_SIGN: begin
					sign_q     <= sign_val;
					count_q    <= '0;
					nib_cnt_q  <= '0;
					acc_q      <= '0;
					neg_flag_q <= 1'b0;
					first_q    <= 1'b0;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					if (nib_done) begin
						count_q   <= count_q + 1'b1;
						nib_cnt_q <= '0;
						if (!more_digits) begin
							state_q <= sign_q ? ST_OSIGN : ST_ODIG;
						end
					end else begin
						nib_cnt_q <= nib_cnt_q + 1'b1;
					end
				end
				ST_OSIGN: begin
					if (load_ok) begin
						state_q <= ST_ODIG;
					end
				end
				ST_ODIG: begin
					if (load_ok) begin
						count_q <= count_q - 1'b1;
						if (count_q == irc_pkg::COUNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && dv[DW]) begin
					digit_q <= dv[DW-1:0];
					prod_q  <= '0;
				end
			end
			ST_MUL: begin
				prod_q <= prod_next;
			end
			ST_SIGN: begin
				div_q <= mag;
				rem_q <= '0;
			end
			ST_DIV: begin
				div_q <= div_next;
				if (nib_done) begin
					// push the digit; the most significant one ends up on top
					stack_q <= {stack_q[irc_pkg::STACK_W-DW-1:0], rem_next};
					rem_q   <= '0;
				end else begin
					rem_q <= rem_next;
				end
			end
			ST_OSIGN: begin
				if (load_ok) begin
					out_data_q.out_char <= irc_pkg::CHAR_MINUS;
					out_data_q.out_last <= 1'b0;
				end
			end
			ST_ODIG: begin
				if (load_ok) begin
					out_data_q.out_char <= irc_pkg::char_of(stack_q[DW-1:0]);
					out_data_q.out_last <= (count_q == irc_pkg::COUNT_W'(1));
					stack_q             <= {{DW{1'b0}}, stack_q[irc_pkg::STACK_W-1:DW]};
				end
			end
			default: ;
		endcase
	end

endmodule

### sv/irc_checker.sv
// Port-level checks for the radix converter, bound to the top level.
`timescale 1ns / 1ps

module irc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input irc_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_stall,
	input irc_pkg::out_t out_data
);

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// The sign never closes a number.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_char == irc_pkg::CHAR_MINUS |-> !out_data.out_last)
		else $error("minus sign marked as last character");

	// Emitted characters are a sign or a base-16 digit.
	a_out_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.out_char == irc_pkg::CHAR_MINUS)
			|| (out_data.out_char >= irc_pkg::CHAR_ZERO
				&& out_data.out_char <= irc_pkg::CHAR_NINE)
			|| (out_data.out_char >= irc_pkg::CHAR_A
				&& out_data.out_char <= irc_pkg::CHAR_F))
		else $error("illegal output character");

	// A final character starts conversion, so input stalls next cycle.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.last_char |=> in_stall)
		else $error("input taken while converting");

endmodule

bind integer_radix_converter_core irc_checker u_irc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
